### rtl/rcpd_pkg.sv
// Package for the RC pulse channel decoder.
// Holds the field widths, reset values, register indexes and the shared types.
// No dependencies.
package rcpd_pkg;

   localparam int TimeWidth    = 32;
   localparam int PulseWidth   = 12;
   localparam int GainWidth    = 24;
   localparam int AmpWidth     = 15;
   localparam int ValueWidth   = 32;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 24;

   localparam logic [15:0] WidthLimit = 16'd2200;
   localparam logic [PulseWidth-1:0] WidthSubst = 12'd1500;

   localparam logic [PulseWidth-1:0] ZeroWidthReset = 12'd1500;
   localparam logic [GainWidth-1:0]  GainReset      = 24'd65536;
   localparam logic [AmpWidth-1:0]   AmpReset       = 15'd100;
   localparam logic [PulseWidth-1:0] RangeLowReset  = 12'd1500;

   // Reciprocals for the switch thresholds, exact for any 15-bit amplitude.
   localparam logic [15:0] RecipFive  = 16'd52429;
   localparam logic [15:0] RecipThree = 16'd43691;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_CHANNEL_TYPE = 3'd0,
      CSR_ZERO_WIDTH   = 3'd1,
      CSR_UPPER_GAIN   = 3'd2,
      CSR_LOWER_GAIN   = 3'd3,
      CSR_AMPLITUDE    = 3'd4,
      CSR_TRACK_RANGE  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      CHAN_PROPORTIONAL = 2'd0,
      CHAN_TWO_POSITION = 2'd1,
      CHAN_THREE_POSITION = 2'd2
   } chan_type;

   typedef logic [1:0] chan_code_type;

   typedef struct packed {
      chan_code_type               chan_mode;
      logic [PulseWidth-1:0]       zero_width_us;
      logic [GainWidth-1:0]        upper_gain;
      logic [GainWidth-1:0]        lower_gain;
      logic [AmpWidth-1:0]         amplitude;
      logic                        track_range;
   } cfg_type;

   function automatic logic [AmpWidth-1:0] div_five(input logic [AmpWidth-1:0] a);
      logic [AmpWidth+15:0] p;
      p = a * RecipFive;
      return {2'b00, p[AmpWidth+15:18]};
   endfunction

   function automatic logic [AmpWidth-1:0] div_three(input logic [AmpWidth-1:0] a);
      logic [AmpWidth+15:0] p;
      p = a * RecipThree;
      return {1'b0, p[AmpWidth+15:17]};
   endfunction

endpackage

### rtl/rcpd_csr.sv
// Configuration registers of the RC pulse channel decoder.
// Depends on rcpd_pkg for the register indexes and the configuration struct.
module rcpd_csr import rcpd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_CHANNEL_TYPE: cfg_in.chan_mode     = csr_data[1:0];
            CSR_ZERO_WIDTH:   cfg_in.zero_width_us = csr_data[PulseWidth-1:0];
            CSR_UPPER_GAIN:   cfg_in.upper_gain    = csr_data[GainWidth-1:0];
            CSR_LOWER_GAIN:   cfg_in.lower_gain    = csr_data[GainWidth-1:0];
            CSR_AMPLITUDE:    cfg_in.amplitude     = csr_data[AmpWidth-1:0];
            CSR_TRACK_RANGE:  cfg_in.track_range   = csr_data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chan_mode     <= CHAN_PROPORTIONAL;
         cfg_ff.zero_width_us <= ZeroWidthReset;
         cfg_ff.upper_gain    <= GainReset;
         cfg_ff.lower_gain    <= GainReset;
         cfg_ff.amplitude     <= AmpReset;
         cfg_ff.track_range   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/rcpd_map.sv
// Value mapping of the RC pulse channel decoder: offset from neutral, then
// proportional scaling or switch thresholds. Depends on rcpd_pkg.
module rcpd_map import rcpd_pkg::*; (
   input  cfg_type                       cfg,
   input  logic [PulseWidth-1:0]         pulse_width,
   output logic signed [ValueWidth-1:0]  channel_value
);

   logic [PulseWidth:0]            offset;
   logic                           negative;
   logic [PulseWidth-1:0]          magnitude;
   logic [GainWidth-1:0]           gain;
   logic [PulseWidth+GainWidth-1:0] product;
   logic [PulseWidth+GainWidth:0]  rounded;
   logic [ValueWidth-1:0]          scaled;
   logic [ValueWidth-1:0]          amp_q8;
   logic [AmpWidth-1:0]            limit_five;
   logic [AmpWidth-1:0]            limit_three;
   logic [AmpWidth:0]              mag_ext;

   always_comb begin
      offset    = {1'b0, pulse_width} - {1'b0, cfg.zero_width_us};
      negative  = offset[PulseWidth];
      magnitude = negative ? PulseWidth'(-offset) : offset[PulseWidth-1:0];
      gain      = negative ? cfg.lower_gain : cfg.upper_gain;
      product   = magnitude * gain;
      rounded   = {1'b0, product} + (PulseWidth+GainWidth+1)'(128);
      scaled    = ValueWidth'(rounded[PulseWidth+GainWidth:8]);
      amp_q8    = ValueWidth'({cfg.amplitude, 8'd0});
      limit_five  = div_five(cfg.amplitude);
      limit_three = div_three(cfg.amplitude);
      mag_ext   = (AmpWidth+1)'(magnitude);

      case (cfg.chan_mode)
         CHAN_PROPORTIONAL: begin
            channel_value = negative ? -$signed(scaled) : $signed(scaled);
         end
         CHAN_TWO_POSITION: begin
            if (negative && (mag_ext > {1'b0, limit_five})) begin
               channel_value = -$signed(amp_q8);
            end else begin
               channel_value = $signed(amp_q8);
            end
         end
         CHAN_THREE_POSITION: begin
            if (mag_ext > {1'b0, limit_three}) begin
               channel_value = negative ? -$signed(amp_q8) : $signed(amp_q8);
            end else begin
               channel_value = '0;
            end
         end
         default: channel_value = '0;
      endcase
   end

endmodule

### rtl/rc_pulse_channel_decoder.sv
// RC pulse channel decoder. Each req beat is one pin-change event. A rising
// level only records the start time; a falling level yields one rsp beat with
// the pulse width (1500 if over 2200), its mapped Q.8 value and the tracked
// width range. Every event passes an input register and, when falling, a
// result register, with the width, offset, gain multiply and rounding between
// them. With rsp not stalled the block takes one beat per cycle; rsp_valid
// rises as a falling event moves from the input register into the result
// register. While a result waits under rsp_stall, one more event can enter
// the input register, and req_stall then stays high until the result is taken.
// Depends on rcpd_pkg, rcpd_csr and rcpd_map.
module rc_pulse_channel_decoder import rcpd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_pin_level,
   input  logic [TimeWidth-1:0]     req_time_us,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [PulseWidth-1:0]    rsp_pulse_width,
   output logic signed [ValueWidth-1:0] rsp_channel_value,
   output logic [PulseWidth-1:0]    rsp_width_min,
   output logic [PulseWidth-1:0]    rsp_width_max
);

   cfg_type cfg;

   logic                   s1_valid_ff;
   logic                   s1_level_ff;
   logic [TimeWidth-1:0]   s1_time_ff;
   logic [TimeWidth-1:0]   pulse_start_ff;
   logic [PulseWidth-1:0]  range_low_ff;
   logic [PulseWidth-1:0]  range_high_ff;
   logic [PulseWidth-1:0]  range_low_in;
   logic [PulseWidth-1:0]  range_high_in;

   logic                   out_valid_ff;
   logic [PulseWidth-1:0]  out_width_ff;
   logic signed [ValueWidth-1:0] out_value_ff;
   logic [PulseWidth-1:0]  out_min_ff;
   logic [PulseWidth-1:0]  out_max_ff;

   logic                   advance;
   logic                   accept;
   logic                   retire;
   logic [TimeWidth-1:0]   elapsed;
   logic [PulseWidth-1:0]  width;
   logic signed [ValueWidth-1:0] value;

   rcpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rcpd_map u_map (
      .cfg           (cfg),
      .pulse_width   (width),
      .channel_value (value)
   );

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign retire    = s1_valid_ff && advance;

   always_comb begin
      elapsed = s1_time_ff - pulse_start_ff;
      if (elapsed[15:0] > WidthLimit) begin
         width = WidthSubst;
      end else begin
         width = elapsed[PulseWidth-1:0];
      end
      range_low_in  = range_low_ff;
      range_high_in = range_high_ff;
      if (cfg.track_range) begin
         if (width > range_high_ff) begin
            range_high_in = width;
         end
         if (width < range_low_ff) begin
            range_low_in = width;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         pulse_start_ff <= '0;
         range_low_ff   <= RangeLowReset;
         range_high_ff  <= '0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (retire) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= s1_valid_ff && !s1_level_ff;
         end
         if (retire) begin
            if (s1_level_ff) begin
               pulse_start_ff <= s1_time_ff;
            end else begin
               range_low_ff  <= range_low_in;
               range_high_ff <= range_high_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_level_ff <= req_pin_level;
         s1_time_ff  <= req_time_us;
      end
      if (retire && !s1_level_ff) begin
         out_width_ff <= width;
         out_value_ff <= value;
         out_min_ff   <= range_low_in;
         out_max_ff   <= range_high_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pulse_width   = out_width_ff;
   assign rsp_channel_value = out_value_ff;
   assign rsp_width_min     = out_min_ff;
   assign rsp_width_max     = out_max_ff;

endmodule
